[hdl/gmsbd_pkg.sv]
package gmsbd_pkg;

   localparam logic [1:0] CELL_OPEN    = 2'd0;
   localparam logic [1:0] CELL_SOURCE  = 2'd1;
   localparam logic [1:0] CELL_BLOCKED = 2'd2;

   localparam logic [1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [1:0] CSR_GRID_ROWS = 2'd1;

   localparam int CSR_DATA_W = 9;
   localparam int DIST_OUT_W = 16;

   typedef struct packed {
      logic valid;
      logic source;
      logic [1:0] code;
   } load_ctl_type;

endpackage

[hdl/grid_multi_source_bfs_distance_top.sv]
// channel   ports                                   transfer
// request   start, busy, req_cell_code              start & !busy
// response  rsp_strobe, rsp_max_distance,           rsp_strobe, one cycle
//           rsp_unreachable
// csr       csr_valid, csr_ready, csr_index,        csr_valid & csr_ready
//           csr_wdata
//
// cells load at one per cycle while busy is low; the last cell of a job raises busy
// the flood then reads, divides and checks the neighbors of each queued cell,
// and a final scan goes over the cells of the job.
// reset is synchronous and needs no clearing pass; each load writes its own entry
// the response cannot be stalled; busy drops the cycle after rsp_strobe
module grid_multi_source_bfs_distance_top
   import gmsbd_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_cell_code,
   output logic                   rsp_strobe,
   output logic [DIST_OUT_W-1:0]  rsp_max_distance,
   output logic                   rsp_unreachable,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CAP = MAX_ROWS * MAX_COLS;
   localparam int AW  = $clog2(CAP);
   localparam int NW  = AW + 1;
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int CW  = $clog2(MAX_COLS + 1);
   localparam int JW  = RW + CW + NW;

   load_ctl_type  load_ctl;
   logic [AW-1:0] load_addr;
   logic          job_push, job_pop, job_valid, back_busy;
   logic [RW-1:0] f_rows, b_rows;
   logic [CW-1:0] f_cols, b_cols;
   logic [NW-1:0] f_total, b_total;

   assign busy = job_valid || back_busy;

   gmsbd_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cell_code (req_cell_code),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .load_ctl      (load_ctl),
      .load_addr     (load_addr),
      .job_push      (job_push),
      .job_rows      (f_rows),
      .job_cols      (f_cols),
      .job_total     (f_total)
   );

   gmsbd_job_fifo #(
      .WIDTH (JW)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({f_rows, f_cols, f_total}),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  ({b_rows, b_cols, b_total})
   );

   gmsbd_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .load_ctl         (load_ctl),
      .load_addr        (load_addr),
      .job_valid        (job_valid),
      .job_rows         (b_rows),
      .job_cols         (b_cols),
      .job_total        (b_total),
      .job_pop          (job_pop),
      .back_busy        (back_busy),
      .rsp_strobe       (rsp_strobe),
      .rsp_max_distance (rsp_max_distance),
      .rsp_unreachable  (rsp_unreachable)
   );

endmodule

[hdl/gmsbd_job_fifo.sv]
module gmsbd_job_fifo
   import gmsbd_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop && count_ff != 2'd0) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push && count_in != 2'd2) begin
         if (count_in == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot0_ff;

endmodule

[hdl/gmsbd_front.sv]
module gmsbd_front
   import gmsbd_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256,
   localparam int CAP = MAX_ROWS * MAX_COLS,
   localparam int AW  = $clog2(CAP),
   localparam int NW  = AW + 1,
   localparam int RW  = $clog2(MAX_ROWS + 1),
   localparam int CW  = $clog2(MAX_COLS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [1:0]             req_cell_code,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output load_ctl_type           load_ctl,
   output logic [AW-1:0]          load_addr,
   output logic                   job_push,
   output logic [RW-1:0]          job_rows,
   output logic [CW-1:0]          job_cols,
   output logic [NW-1:0]          job_total
);

   logic [CSR_DATA_W-1:0] cols_reg_ff, cols_reg_in, rows_reg_ff, rows_reg_in;
   logic [NW-1:0]         count_ff, count_in;
   logic [RW-1:0]         rows_c;
   logic [CW-1:0]         cols_c;
   logic [NW-1:0]         total_c, count_next;
   logic                  accept, last;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      cols_reg_in = cols_reg_ff;
      rows_reg_in = rows_reg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GRID_COLS: cols_reg_in = csr_wdata;
            CSR_GRID_ROWS: rows_reg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // zero counts as one, oversize clamps to the maximum
   always_comb begin
      if (cols_reg_ff == '0) begin
         cols_c = CW'(1);
      end else if (32'(cols_reg_ff) > 32'(MAX_COLS)) begin
         cols_c = CW'(MAX_COLS);
      end else begin
         cols_c = CW'(cols_reg_ff);
      end
      if (rows_reg_ff == '0) begin
         rows_c = RW'(1);
      end else if (32'(rows_reg_ff) > 32'(MAX_ROWS)) begin
         rows_c = RW'(MAX_ROWS);
      end else begin
         rows_c = RW'(rows_reg_ff);
      end
   end

   assign total_c    = NW'(NW'(rows_c) * NW'(cols_c));
   assign count_next = count_ff + NW'(1);
   assign last       = (count_next >= total_c);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_reg_ff <= CSR_DATA_W'(1);
         rows_reg_ff <= CSR_DATA_W'(1);
         count_ff    <= '0;
      end else begin
         cols_reg_ff <= cols_reg_in;
         rows_reg_ff <= rows_reg_in;
         count_ff    <= count_in;
      end
   end

   assign load_ctl.valid  = accept;
   assign load_ctl.source = (req_cell_code == CELL_SOURCE);
   assign load_ctl.code   = req_cell_code;
   assign load_addr       = count_ff[AW-1:0];
   assign job_push        = accept && last;
   assign job_rows        = rows_c;
   assign job_cols        = cols_c;
   assign job_total       = total_c;

endmodule

[hdl/gmsbd_back.sv]
module gmsbd_back
   import gmsbd_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256,
   localparam int CAP = MAX_ROWS * MAX_COLS,
   localparam int AW  = $clog2(CAP),
   localparam int NW  = AW + 1,
   localparam int RW  = $clog2(MAX_ROWS + 1),
   localparam int CW  = $clog2(MAX_COLS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  load_ctl_type           load_ctl,
   input  logic [AW-1:0]          load_addr,
   input  logic                   job_valid,
   input  logic [RW-1:0]          job_rows,
   input  logic [CW-1:0]          job_cols,
   input  logic [NW-1:0]          job_total,
   output logic                   job_pop,
   output logic                   back_busy,
   output logic                   rsp_strobe,
   output logic [DIST_OUT_W-1:0]  rsp_max_distance,
   output logic                   rsp_unreachable
);

   localparam int DCW = $clog2(AW) + 1;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_POP  = 10'b0000000010,
      S_QRD  = 10'b0000000100,
      S_CURD = 10'b0000001000,
      S_DIV  = 10'b0000010000,
      S_NBR  = 10'b0000100000,
      S_CHK  = 10'b0001000000,
      S_SRD  = 10'b0010000000,
      S_SEV  = 10'b0100000000,
      S_DONE = 10'b1000000000
   } state_type;

   logic [1:0]  cell_mem  [CAP];
   logic [AW:0] dist_mem  [CAP];
   logic [AW-1:0] queue_mem [CAP];

   state_type   state_ff, state_in;
   logic [RW-1:0] rows_ff, rows_in;
   logic [CW-1:0] cols_ff, cols_in;
   logic [NW-1:0] total_ff, total_in, head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic [AW-1:0] cur_ff, cur_in, curd_ff, curd_in, quo_ff, quo_in;
   logic [AW-1:0] nidx_ff, nidx_in, maxd_ff, maxd_in;
   logic [CW:0]   rem_ff, rem_in, rem_sh;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [1:0]    k_ff, k_in;
   logic          unr_ff, unr_in;

   logic [1:0]    cell_rd_ff;
   logic [AW:0]   dist_rd_ff;
   logic [AW-1:0] q_rd_ff;

   logic [AW-1:0] rd_addr, nbr_idx;
   logic          nbr_ok;
   logic          dist_we, q_we;
   logic [AW-1:0] dist_waddr, q_waddr, q_wdata;
   logic [AW:0]   dist_wdata;

   // neighbor order: down, up, right, left
   always_comb begin
      nbr_ok  = 1'b0;
      nbr_idx = cur_ff;
      case (k_ff)
         2'd0: begin
            nbr_ok  = (NW'(quo_ff) + NW'(1)) < NW'(rows_ff);
            nbr_idx = cur_ff + AW'(cols_ff);
         end
         2'd1: begin
            nbr_ok  = (quo_ff != '0);
            nbr_idx = cur_ff - AW'(cols_ff);
         end
         2'd2: begin
            nbr_ok  = (rem_ff + (CW + 1)'(1)) < (CW + 1)'(cols_ff);
            nbr_idx = cur_ff + AW'(1);
         end
         default: begin
            nbr_ok  = (rem_ff != '0);
            nbr_idx = cur_ff - AW'(1);
         end
      endcase
   end

   assign rem_sh = {rem_ff[CW-1:0], quo_ff[AW-1]};

   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      total_in = total_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      scan_in  = scan_ff;
      cur_in   = cur_ff;
      curd_in  = curd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      k_in     = k_ff;
      nidx_in  = nidx_ff;
      maxd_in  = maxd_ff;
      unr_in   = unr_ff;
      job_pop  = 1'b0;
      rd_addr  = '0;
      dist_we  = 1'b0;
      dist_waddr = load_addr;
      dist_wdata = {load_ctl.source, AW'(0)};
      q_we     = 1'b0;
      q_waddr  = tail_ff[AW-1:0];
      q_wdata  = load_addr;
      case (state_ff)
         S_IDLE: begin
            if (load_ctl.valid) begin
               dist_we = 1'b1;
               if (load_ctl.source && tail_ff < NW'(CAP)) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + NW'(1);
               end
            end
            if (job_valid) begin
               job_pop  = 1'b1;
               rows_in  = job_rows;
               cols_in  = job_cols;
               total_in = job_total;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (head_ff < tail_ff) begin
               head_in  = head_ff + NW'(1);
               state_in = S_QRD;
            end else begin
               scan_in  = '0;
               maxd_in  = '0;
               unr_in   = 1'b0;
               state_in = S_SRD;
            end
         end
         S_QRD: begin
            cur_in   = q_rd_ff;
            rd_addr  = q_rd_ff;
            state_in = S_CURD;
         end
         S_CURD: begin
            curd_in  = dist_rd_ff[AW-1:0];
            quo_in   = cur_ff;
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         // restoring divide of the cell index by the column count
         S_DIV: begin
            if (rem_sh >= (CW + 1)'(cols_ff)) begin
               rem_in = rem_sh - (CW + 1)'(cols_ff);
               quo_in = {quo_ff[AW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[AW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(AW - 1)) begin
               k_in     = 2'd0;
               state_in = S_NBR;
            end
         end
         S_NBR: begin
            if (nbr_ok) begin
               nidx_in  = nbr_idx;
               rd_addr  = nbr_idx;
               state_in = S_CHK;
            end else if (k_ff == 2'd3) begin
               state_in = S_POP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_CHK: begin
            if (cell_rd_ff < CELL_BLOCKED && !dist_rd_ff[AW]) begin
               dist_we    = 1'b1;
               dist_waddr = nidx_ff;
               dist_wdata = {1'b1, curd_ff + AW'(1)};
               if (tail_ff < NW'(CAP)) begin
                  q_we    = 1'b1;
                  q_wdata = nidx_ff;
                  tail_in = tail_ff + NW'(1);
               end
            end
            if (k_ff == 2'd3) begin
               state_in = S_POP;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_NBR;
            end
         end
         S_SRD: begin
            if (scan_ff < total_ff) begin
               rd_addr  = scan_ff[AW-1:0];
               state_in = S_SEV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SEV: begin
            scan_in  = scan_ff + NW'(1);
            state_in = S_SRD;
            if (dist_rd_ff[AW]) begin
               if (dist_rd_ff[AW-1:0] > maxd_ff) begin
                  maxd_in = dist_rd_ff[AW-1:0];
               end
            end else if (cell_rd_ff < CELL_BLOCKED) begin
               unr_in   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            head_in  = '0;
            tail_in  = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_ctl.valid) begin
         cell_mem[load_addr] <= load_ctl.code;
      end
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      cell_rd_ff <= cell_mem[rd_addr];
      dist_rd_ff <= dist_mem[rd_addr];
      q_rd_ff    <= queue_mem[head_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      rows_ff  <= rows_in;
      cols_ff  <= cols_in;
      total_ff <= total_in;
      scan_ff  <= scan_in;
      cur_ff   <= cur_in;
      curd_ff  <= curd_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      k_ff     <= k_in;
      nidx_ff  <= nidx_in;
      maxd_ff  <= maxd_in;
      unr_ff   <= unr_in;
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   assign back_busy       = (state_ff != S_IDLE);
   assign rsp_strobe      = (state_ff == S_DONE);
   assign rsp_unreachable = unr_ff;

   always_comb begin
      if (unr_ff) begin
         rsp_max_distance = '0;
      end else if (32'(maxd_ff) > 32'(16'hFFFF)) begin
         rsp_max_distance = 16'hFFFF;
      end else begin
         rsp_max_distance = DIST_OUT_W'(maxd_ff);
      end
   end

endmodule

[sim/tb_top.sv]
module tb_top;
   import gmsbd_pkg::*;

   localparam int CELL_CAP = 256 * 256;
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [1:0] CELL_CODE3  = 2'd3;
   localparam int STALL_LIMIT = 400000;

   typedef struct {
      logic [15:0] max_distance;
      logic        unreachable;
   } flood_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_cell_code;
   logic                  rsp_strobe;
   logic [DIST_OUT_W-1:0] rsp_max_distance;
   logic                  rsp_unreachable;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   grid_multi_source_bfs_distance_top dut (.*);

   // shadow of the block state
   logic [8:0]    cols_reg, rows_reg;
   logic [1:0]    grid_cells[CELL_CAP];
   int            cells_loaded;
   flood_result_type pending_results[$];
   int            sender_gap_pct;
   int            mismatches;
   int            idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int clamp_size(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic flood_result_type flood_distance(int rows, int cols);
      flood_result_type res;
      int total, head, cur, r, c, nr, nc, idx, k, maxd;
      int frontier[$];
      bit seen[];
      int cell_dist[];
      int dr[4] = '{1, -1, 0, 0};
      int dc[4] = '{0, 0, 1, -1};
      total = rows * cols;
      seen = new[total];
      cell_dist = new[total];
      for (int i = 0; i < total; i++) begin
         seen[i] = (grid_cells[i] == CELL_SOURCE);
         cell_dist[i] = 0;
         if (seen[i]) frontier.push_back(i);
      end
      head = 0;
      while (head < frontier.size()) begin
         cur = frontier[head];
         head++;
         r = cur / cols;
         c = cur % cols;
         for (k = 0; k < 4; k++) begin
            nr = r + dr[k];
            nc = c + dc[k];
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            idx = nr * cols + nc;
            if (grid_cells[idx] >= CELL_BLOCKED || seen[idx]) continue;
            seen[idx] = 1'b1;
            cell_dist[idx] = cell_dist[cur] + 1;
            frontier.push_back(idx);
         end
      end
      maxd = 0;
      res.unreachable = 1'b0;
      for (int i = 0; i < total; i++) begin
         if (seen[i]) begin
            if (cell_dist[i] > maxd) maxd = cell_dist[i];
         end else if (grid_cells[i] < CELL_BLOCKED) begin
            res.unreachable = 1'b1;
         end
      end
      if (res.unreachable) maxd = 0;
      if (maxd > 65535) maxd = 65535;
      res.max_distance = maxd[15:0];
      return res;
   endfunction

   task automatic send_cell(logic [1:0] code);
      int total;
      // idle cycles before offering the transaction
      while ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cell_code <= code;
      do @(posedge clock); while (busy);
      total = clamp_size(rows_reg) * clamp_size(cols_reg);
      grid_cells[cells_loaded] = code;
      cells_loaded++;
      if (cells_loaded >= total) begin
         pending_results.push_back(flood_distance(clamp_size(rows_reg), clamp_size(cols_reg)));
         cells_loaded = 0;
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_GRID_COLS) cols_reg = value;
      else if (index == CSR_GRID_ROWS) rows_reg = value;
      @(posedge clock);
   endtask

   task automatic set_grid(logic [8:0] rows, logic [8:0] cols);
      wait_drained();
      write_csr(CSR_GRID_ROWS, rows);
      write_csr(CSR_GRID_COLS, cols);
   endtask

   task automatic send_grid(string cells);
      for (int i = 0; i < cells.len(); i++) begin
         case (cells[i])
            "S": send_cell(CELL_SOURCE);
            "#": send_cell(CELL_BLOCKED);
            "x": send_cell(CELL_CODE3);
            default: send_cell(CELL_OPEN);
         endcase
      end
   endtask

   function automatic logic [1:0] random_cell();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return CELL_SOURCE;
      if (roll < 30) return CELL_BLOCKED;
      if (roll < 35) return CELL_CODE3;
      return CELL_OPEN;
   endfunction

   task automatic test_single_cells();
      set_grid(9'd1, 9'd1);
      send_cell(CELL_OPEN);
      send_cell(CELL_SOURCE);
      send_cell(CELL_BLOCKED);
      send_cell(CELL_CODE3);
      // zero size counts as one
      set_grid(9'd0, 9'd0);
      send_cell(CELL_SOURCE);
      send_cell(CELL_OPEN);
   endtask

   task automatic test_small_grids();
      set_grid(9'd3, 9'd3);
      send_grid("S........");
      send_grid("#########");
      send_grid("xx#x##x#x");
      send_grid("S#.##....");
      send_grid("..S.x...S");
      // spare register slots do nothing
      wait_drained();
      write_csr(CSR_SPARE_2, 9'h1ff);
      write_csr(CSR_SPARE_3, 9'h0aa);
      send_grid("S...x..#.");
   endtask

   task automatic test_extreme_sizes();
      // oversize clamps to one full row or column
      set_grid(9'd1, 9'h1ff);
      for (int i = 0; i < 256; i++) send_cell(i == 255 ? CELL_SOURCE : CELL_OPEN);
      set_grid(9'h1ff, 9'd1);
      for (int i = 0; i < 256; i++) send_cell(i == 7 ? CELL_SOURCE : random_cell());
   endtask

   task automatic test_random_jobs(int items, int gap_pct);
      int sent, total;
      sender_gap_pct = gap_pct;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) == 0)
            set_grid(9'($urandom_range(1, 24)), 9'($urandom_range(1, 24)));
         else
            set_grid(9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)));
         total = clamp_size(rows_reg) * clamp_size(cols_reg);
         for (int i = 0; i < total; i++) send_cell(random_cell());
         sent += total;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      flood_result_type exp_res;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: max_distance %0d unreachable %0d",
                        rsp_max_distance, rsp_unreachable);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_max_distance !== exp_res.max_distance ||
                rsp_unreachable !== exp_res.unreachable) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected max_distance %0d unreachable %0d, got %0d %0d",
                           exp_res.max_distance, exp_res.unreachable,
                           rsp_max_distance, rsp_unreachable);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cell_code = CELL_OPEN;
      csr_valid = 1'b0;
      csr_index = CSR_GRID_COLS;
      csr_wdata = '0;
      cols_reg = 9'd1;
      rows_reg = 9'd1;
      cells_loaded = 0;
      sender_gap_pct = 0;
      mismatches = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_gap_pct = 10;
      test_single_cells();
      test_small_grids();
      test_extreme_sizes();
      test_random_jobs(150, 10);
      test_random_jobs(150, 57);
      test_random_jobs(150, 0);
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
hdl/gmsbd_pkg.sv
hdl/gmsbd_job_fifo.sv
hdl/gmsbd_front.sv
hdl/gmsbd_back.sv
hdl/grid_multi_source_bfs_distance_top.sv
sim/tb_top.sv
